FILE: rtl/i2cm_pkg.sv
// Shared types for the I2C register access master: request codes and channel payloads.
package i2cm_pkg;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_LOAD  = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic        sda_in;
        logic [7:0]  device_addr;
        logic [7:0]  reg_addr;
        logic [4:0]  byte_count;
        logic [3:0]  load_index;
        logic [7:0]  load_byte;
    } t_req_item;

    typedef struct packed {
        logic        scl_level;
        logic        sda_release;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        busy_res;
        logic        done_res;
        logic        nack_seen;
    } t_rsp_item;

    localparam logic [5:0] START_SLOTS = 6'd4;
    localparam logic [5:0] TX_SLOTS    = 6'd20;
    localparam logic [5:0] RX_SLOTS    = 6'd33;
    localparam logic [5:0] SHORT_SLOTS = 6'd3;
    localparam logic [5:0] BIT_SLOTS   = 6'd16;
    localparam logic [5:0] ACK_SLOT    = 6'd18;
    localparam logic [5:0] RX_LAST     = 6'd32;

endpackage

FILE: rtl/i2cm_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface i2cm_stream_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/i2c_master_register_access.sv
// Top level of the I2C register access master.
//
// Usage: requests arrive on i_req (valid/ready, payload i2cm_pkg::t_req_item) and every
// accepted request yields exactly one response on o_rsp (payload i2cm_pkg::t_rsp_item).
// A tick request advances the bus by one time slot and samples sda_in; begin read and
// begin write start a register transaction when the master is idle; a load request fills
// one slot of the write buffer while idle. The response carries the SCL and SDA levels to
// drive, a received byte with its strobe, busy, done and the NACK abort flag.
// The response is registered: the response register holds the result the cycle after the
// request is taken. Throughput is one request per cycle unless o_rsp stalls; all slot
// work is one pass of logic from the phase, slot and byte counters into the state and
// response registers. If the receiver stalls, the response is held and i_req.ready drops
// only while the response register is full and o_rsp.ready is low; otherwise a new
// request is taken in the same cycle the pending response leaves.
// Reset (synchronous, active low) returns the master to idle with both lines released
// high and empties the response register; the write buffer holds no defined data until
// loaded.
module i2c_master_register_access #(
    parameter int MAX_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    i2cm_stream_if.sink           i_req,
    i2cm_stream_if.source         o_rsp
);

    localparam int BUF_DEPTH = (MAX_BYTES < 16) ? MAX_BYTES : 16;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_MAX   = (MAX_BYTES < 31) ? MAX_BYTES : 31;
    localparam logic [4:0] BUF_LIM = 5'(BUF_DEPTH);
    localparam logic [4:0] TOT_MAX = 5'(CNT_MAX);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_DEV, PH_REG, PH_START2,
        PH_DEVR, PH_WDATA, PH_RDATA, PH_ACK, PH_STOP
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [5:0]            r_slot, n_slot;
    logic [4:0]            r_bc, n_bc;
    logic [4:0]            r_total, n_total;
    logic [7:0]            r_shift, n_shift;
    logic [15:0]           r_addrs, n_addrs;
    logic                  r_is_read, n_is_read;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_ack_ok, n_ack_ok;
    logic                  r_aborted, n_aborted;
    logic                  r_out_valid, n_out_valid;
    i2cm_pkg::t_rsp_item   r_out, n_out;
    logic [7:0]            r_buf [BUF_DEPTH];
    logic [7:0]            r_buf_q;

    i2cm_pkg::t_req_item   w_req;
    logic                  w_acc;
    logic [4:0]            w_bc_inc;
    logic [4:0]            w_rd_idx;

    function automatic logic [5:0] seg_len(input t_phase p);
        case (p)
            PH_START1, PH_START2:               seg_len = i2cm_pkg::START_SLOTS;
            PH_DEV, PH_REG, PH_DEVR, PH_WDATA:  seg_len = i2cm_pkg::TX_SLOTS;
            PH_RDATA:                           seg_len = i2cm_pkg::RX_SLOTS;
            default:                            seg_len = i2cm_pkg::SHORT_SLOTS;
        endcase
    endfunction

    assign w_req       = i_req.payload;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_bc_inc    = r_bc + 5'd1;
    assign w_rd_idx    = (r_phase == PH_WDATA) ? w_bc_inc : 5'd0;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_comb begin
        logic [4:0] cnt;
        logic [5:0] s;
        logic [5:0] s_inc;
        logic       rx_valid;
        logic [7:0] rx;
        logic       done;
        logic       nack;
        logic       step_end;

        n_phase   = r_phase;
        n_slot    = r_slot;
        n_bc      = r_bc;
        n_total   = r_total;
        n_shift   = r_shift;
        n_addrs   = r_addrs;
        n_is_read = r_is_read;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack_ok  = r_ack_ok;
        n_aborted = r_aborted;
        cnt       = w_req.byte_count;
        s         = r_slot;
        s_inc     = r_slot + 6'd1;
        rx_valid  = 1'b0;
        rx        = 8'd0;
        done      = 1'b0;
        nack      = 1'b0;
        step_end  = 1'b0;

        if (w_acc) begin
            case (w_req.req_type)
                i2cm_pkg::REQ_READ, i2cm_pkg::REQ_WRITE: begin
                    if (r_phase == PH_IDLE) begin
                        n_is_read = (w_req.req_type == i2cm_pkg::REQ_READ);
                        n_addrs   = {w_req.device_addr, w_req.reg_addr};
                        if (cnt > TOT_MAX) begin
                            cnt = TOT_MAX;
                        end
                        if (n_is_read && cnt == 5'd0) begin
                            cnt = 5'd1;
                        end
                        n_total   = cnt;
                        n_bc      = 5'd0;
                        n_ack_ok  = 1'b0;
                        n_aborted = 1'b0;
                        n_phase   = PH_START1;
                        n_shift   = 8'd0;
                        n_slot    = 6'd0;
                    end
                end
                i2cm_pkg::REQ_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        case (r_phase)
                            PH_START1, PH_START2: begin
                                if (s == 6'd0) begin
                                    n_sda = 1'b1;
                                end else if (s == 6'd1) begin
                                    n_scl = 1'b1;
                                end else if (s == 6'd2) begin
                                    n_sda = 1'b0;
                                end else begin
                                    n_scl = 1'b0;
                                end
                            end
                            PH_DEV, PH_REG, PH_DEVR, PH_WDATA: begin
                                if (s < i2cm_pkg::BIT_SLOTS) begin
                                    if (!s[0]) begin
                                        n_scl = 1'b0;
                                        n_sda = r_shift[3'd7 - s[3:1]];
                                    end else begin
                                        n_scl = 1'b1;
                                    end
                                end else if (s == i2cm_pkg::ACK_SLOT) begin
                                    n_scl    = 1'b1;
                                    n_ack_ok = !w_req.sda_in;
                                end else begin
                                    n_scl = 1'b0;
                                    n_sda = 1'b1;
                                end
                            end
                            PH_RDATA: begin
                                n_sda = 1'b1;
                                if (s >= i2cm_pkg::RX_LAST) begin
                                    n_scl    = 1'b0;
                                    rx       = r_shift;
                                    rx_valid = 1'b1;
                                end else if (s[1:0] == 2'd1) begin
                                    n_scl = 1'b0;
                                end else if (s[1:0] == 2'd2) begin
                                    n_scl   = 1'b1;
                                    n_shift = {r_shift[6:0], w_req.sda_in};
                                end else if (s[1:0] == 2'd3) begin
                                    n_scl = 1'b1;
                                end
                            end
                            PH_ACK: begin
                                if (s == 6'd0) begin
                                    n_scl = 1'b0;
                                    n_sda = ({1'b0, w_bc_inc} < {1'b0, r_total}) ? 1'b0 : 1'b1;
                                end else begin
                                    n_scl = (s == 6'd1);
                                end
                            end
                            default: begin
                                if (s == 6'd0) begin
                                    n_sda = 1'b0;
                                end else if (s == 6'd1) begin
                                    n_scl = 1'b1;
                                end else begin
                                    n_sda = 1'b1;
                                end
                            end
                        endcase

                        n_slot   = s_inc;
                        step_end = (s_inc >= seg_len(r_phase));

                        if (step_end) begin
                            n_slot = 6'd0;
                            case (r_phase)
                                PH_START1: begin
                                    n_phase = PH_DEV;
                                    n_shift = r_addrs[15:8];
                                end
                                PH_DEV: begin
                                    if (!r_is_read && !n_ack_ok) begin
                                        n_aborted = 1'b1;
                                        n_phase   = PH_STOP;
                                    end else begin
                                        n_phase = PH_REG;
                                        n_shift = r_addrs[7:0];
                                    end
                                end
                                PH_REG: begin
                                    if (r_is_read) begin
                                        n_phase = PH_START2;
                                        n_shift = 8'd0;
                                    end else if (!n_ack_ok) begin
                                        n_aborted = 1'b1;
                                        n_phase   = PH_STOP;
                                    end else if (r_total == 5'd0) begin
                                        n_phase = PH_STOP;
                                        n_shift = 8'd0;
                                    end else begin
                                        n_bc    = 5'd0;
                                        n_phase = PH_WDATA;
                                        n_shift = r_buf_q;
                                    end
                                end
                                PH_START2: begin
                                    n_phase = PH_DEVR;
                                    n_shift = r_addrs[15:8] + 8'd1;
                                end
                                PH_DEVR: begin
                                    n_bc    = 5'd0;
                                    n_phase = PH_RDATA;
                                    n_shift = 8'd0;
                                end
                                PH_WDATA: begin
                                    if (!n_ack_ok) begin
                                        n_aborted = 1'b1;
                                        n_phase   = PH_STOP;
                                    end else begin
                                        n_bc = w_bc_inc;
                                        if (w_bc_inc < r_total) begin
                                            n_phase = PH_WDATA;
                                            n_shift = r_buf_q;
                                        end else begin
                                            n_phase = PH_STOP;
                                            n_shift = 8'd0;
                                        end
                                    end
                                end
                                PH_RDATA: begin
                                    n_phase = PH_ACK;
                                end
                                PH_ACK: begin
                                    n_bc    = w_bc_inc;
                                    n_shift = 8'd0;
                                    if (w_bc_inc < r_total) begin
                                        n_phase = PH_RDATA;
                                    end else begin
                                        n_phase = PH_STOP;
                                    end
                                end
                                default: begin
                                    n_phase   = PH_IDLE;
                                    done      = (r_phase == PH_STOP);
                                    nack      = r_aborted && done;
                                    n_aborted = 1'b0;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        n_out.scl_level   = n_scl;
        n_out.sda_release = n_sda;
        n_out.rx_byte     = rx;
        n_out.rx_valid    = rx_valid;
        n_out.busy_res    = (n_phase != PH_IDLE);
        n_out.done_res    = done;
        n_out.nack_seen   = nack;

        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= 6'd0;
            r_bc        <= 5'd0;
            r_total     <= 5'd0;
            r_shift     <= 8'd0;
            r_addrs     <= 16'd0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack_ok    <= 1'b0;
            r_aborted   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_bc        <= n_bc;
            r_total     <= n_total;
            r_shift     <= n_shift;
            r_addrs     <= n_addrs;
            r_is_read   <= n_is_read;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_ok    <= n_ack_ok;
            r_aborted   <= n_aborted;
            r_out_valid <= n_out_valid;
        end
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_req.req_type == i2cm_pkg::REQ_LOAD && r_phase == PH_IDLE
                && {1'b0, w_req.load_index} < BUF_LIM) begin
            r_buf[w_req.load_index[BUF_AW-1:0]] <= w_req.load_byte;
        end
        r_buf_q <= (w_rd_idx < BUF_LIM) ? r_buf[w_rd_idx[BUF_AW-1:0]] : 8'd0;
    end

`ifndef SYNTHESIS
    a_busy_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.busy_res == (r_phase != PH_IDLE)))
        else $error("busy flag disagrees with phase");

    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.nack_seen |-> r_out.done_res && !r_out.busy_res)
        else $error("NACK reported without end of transaction");

    a_rx_enters_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && n_out.rx_valid |=> r_phase == PH_ACK && r_is_read)
        else $error("received byte outside read data phase");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < seg_len(r_phase) && (r_phase != PH_IDLE || r_slot == 6'd0))
        else $error("slot counter out of range");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the I2C register access master: predicts every response.
module tb;

    localparam int MAX_WR_BYTES = 16;
    localparam int TOTAL_ITEMS  = 850;
    localparam int TAIL_ITEMS   = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_START,
        SEG_DEV_ADDR,
        SEG_REG_ADDR,
        SEG_RESTART,
        SEG_DEV_READ,
        SEG_WR_DATA,
        SEG_RD_DATA,
        SEG_RD_ACK,
        SEG_STOP
    } t_seg;

    typedef enum {
        SDA_LOW,
        SDA_HIGH,
        SDA_RANDOM,
        SDA_FLAKY
    } t_sda_pattern;

    typedef struct {
        i2cm_pkg::t_req_item item;
        bit                  hold;
    } t_bus_req;

    logic i_clk;
    logic i_rst_n;

    i2cm_stream_if #(.T_PAYLOAD(i2cm_pkg::t_req_item)) req_if ();
    i2cm_stream_if #(.T_PAYLOAD(i2cm_pkg::t_rsp_item)) rsp_if ();

    i2c_master_register_access #(
        .MAX_BYTES(MAX_WR_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_bus_req            req_backlog[$];
    i2cm_pkg::t_rsp_item rsp_due[$];
    int                  queued;
    int                  mismatches;
    int                  rsp_seen;
    int                  cycle_cnt;
    int                  send_gap;
    int                  rcv_gap;
    logic                req_taken;

    // bus state tracked alongside the block
    t_seg       seg        = SEG_IDLE;
    logic [5:0] slot       = '0;
    logic [4:0] byte_idx   = '0;
    logic [4:0] byte_total = '0;
    logic [7:0] shifter    = '0;
    logic [7:0] dev_addr   = '0;
    logic [7:0] sub_addr   = '0;
    logic       rd_mode    = 1'b0;
    logic       acked      = 1'b0;
    logic       aborted_wr = 1'b0;
    logic       scl_q      = 1'b1;
    logic       sda_q      = 1'b1;
    logic [7:0] wr_buf [MAX_WR_BYTES];

    always #2 i_clk = ~i_clk;

    function automatic logic [5:0] seg_slots(t_seg s);
        case (s)
            SEG_START, SEG_RESTART: return i2cm_pkg::START_SLOTS;
            SEG_DEV_ADDR, SEG_REG_ADDR, SEG_DEV_READ, SEG_WR_DATA: return i2cm_pkg::TX_SLOTS;
            SEG_RD_DATA: return i2cm_pkg::RX_SLOTS;
            default: return i2cm_pkg::SHORT_SLOTS;
        endcase
    endfunction

    task automatic enter_seg(t_seg s, logic [7:0] load);
        seg     = s;
        shifter = load;
        slot    = '0;
    endtask

    task automatic drop_write();
        aborted_wr = 1'b1;
        enter_seg(SEG_STOP, shifter);
    endtask

    task automatic next_seg(output logic fin);
        fin = 1'b0;
        case (seg)
            SEG_START: enter_seg(SEG_DEV_ADDR, dev_addr);
            SEG_DEV_ADDR: begin
                if (!rd_mode && !acked) drop_write();
                else enter_seg(SEG_REG_ADDR, sub_addr);
            end
            SEG_REG_ADDR: begin
                if (rd_mode) begin
                    enter_seg(SEG_RESTART, 8'h00);
                end else if (!acked) begin
                    drop_write();
                end else if (byte_total == 0) begin
                    enter_seg(SEG_STOP, 8'h00);
                end else begin
                    byte_idx = '0;
                    enter_seg(SEG_WR_DATA, wr_buf[0]);
                end
            end
            SEG_RESTART: enter_seg(SEG_DEV_READ, dev_addr + 8'd1);
            SEG_DEV_READ: begin
                byte_idx = '0;
                enter_seg(SEG_RD_DATA, 8'h00);
            end
            SEG_WR_DATA: begin
                if (!acked) begin
                    drop_write();
                end else begin
                    byte_idx = byte_idx + 5'd1;
                    if (byte_idx < byte_total) enter_seg(SEG_WR_DATA, wr_buf[byte_idx[3:0]]);
                    else enter_seg(SEG_STOP, 8'h00);
                end
            end
            SEG_RD_DATA: enter_seg(SEG_RD_ACK, shifter);
            SEG_RD_ACK: begin
                byte_idx = byte_idx + 5'd1;
                if (byte_idx < byte_total) enter_seg(SEG_RD_DATA, 8'h00);
                else enter_seg(SEG_STOP, 8'h00);
            end
            default: begin
                seg  = SEG_IDLE;
                slot = '0;
                fin  = 1'b1;
            end
        endcase
    endtask

    task automatic bus_step(input i2cm_pkg::t_req_item it, output i2cm_pkg::t_rsp_item r);
        logic       fin;
        logic [4:0] cnt;
        r = '0;
        case (it.req_type)
            i2cm_pkg::REQ_READ, i2cm_pkg::REQ_WRITE: begin
                if (seg == SEG_IDLE) begin
                    rd_mode  = (it.req_type == i2cm_pkg::REQ_READ);
                    dev_addr = it.device_addr;
                    sub_addr = it.reg_addr;
                    cnt = (it.byte_count > MAX_WR_BYTES) ? 5'(MAX_WR_BYTES) : it.byte_count;
                    if (rd_mode && cnt == 0) cnt = 5'd1;
                    byte_total = cnt;
                    byte_idx   = '0;
                    acked      = 1'b0;
                    aborted_wr = 1'b0;
                    enter_seg(SEG_START, 8'h00);
                end
            end
            i2cm_pkg::REQ_LOAD: begin
                if (seg == SEG_IDLE && int'(it.load_index) < MAX_WR_BYTES)
                    wr_buf[it.load_index] = it.load_byte;
            end
            default: begin
                if (seg != SEG_IDLE) begin
                    case (seg)
                        SEG_START, SEG_RESTART: begin
                            if (slot == 0) sda_q = 1'b1;
                            else if (slot == 1) scl_q = 1'b1;
                            else if (slot == 2) sda_q = 1'b0;
                            else scl_q = 1'b0;
                        end
                        SEG_DEV_ADDR, SEG_REG_ADDR, SEG_DEV_READ, SEG_WR_DATA: begin
                            if (slot < i2cm_pkg::BIT_SLOTS) begin
                                if (!slot[0]) begin
                                    scl_q = 1'b0;
                                    sda_q = shifter[3'd7 - slot[3:1]];
                                end else begin
                                    scl_q = 1'b1;
                                end
                            end else if (slot == i2cm_pkg::ACK_SLOT) begin
                                scl_q = 1'b1;
                                acked = !it.sda_in;
                            end else begin
                                scl_q = 1'b0;
                                sda_q = 1'b1;
                            end
                        end
                        SEG_RD_DATA: begin
                            sda_q = 1'b1;
                            if (slot >= i2cm_pkg::RX_LAST) begin
                                scl_q      = 1'b0;
                                r.rx_byte  = shifter;
                                r.rx_valid = 1'b1;
                            end else if (slot[1:0] == 2'd1) begin
                                scl_q = 1'b0;
                            end else if (slot[1:0] == 2'd2) begin
                                scl_q   = 1'b1;
                                shifter = {shifter[6:0], it.sda_in};
                            end else if (slot[1:0] == 2'd3) begin
                                scl_q = 1'b1;
                            end
                        end
                        SEG_RD_ACK: begin
                            if (slot == 0) begin
                                scl_q = 1'b0;
                                sda_q = (byte_idx + 5'd1 < byte_total) ? 1'b0 : 1'b1;
                            end else begin
                                scl_q = (slot == 1);
                            end
                        end
                        default: begin
                            if (slot == 0) sda_q = 1'b0;
                            else if (slot == 1) scl_q = 1'b1;
                            else sda_q = 1'b1;
                        end
                    endcase
                    slot = slot + 6'd1;
                    if (slot >= seg_slots(seg)) begin
                        next_seg(fin);
                        if (fin) begin
                            r.done_res  = 1'b1;
                            r.nack_seen = aborted_wr;
                            aborted_wr  = 1'b0;
                        end
                    end
                end
            end
        endcase
        r.scl_level   = scl_q;
        r.sda_release = sda_q;
        r.busy_res    = (seg != SEG_IDLE);
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("tb: %s mismatch on response %0d: got %0h, want %0h",
                 what, rsp_seen, got, want);
    endtask

    task automatic compare_rsp(i2cm_pkg::t_rsp_item got, i2cm_pkg::t_rsp_item want);
        if (got.scl_level != want.scl_level)
            flag_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.sda_release != want.sda_release)
            flag_mismatch("sda_release", got.sda_release, want.sda_release);
        if (got.rx_byte != want.rx_byte)
            flag_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.rx_valid != want.rx_valid)
            flag_mismatch("rx_valid", got.rx_valid, want.rx_valid);
        if (got.busy_res != want.busy_res)
            flag_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.done_res != want.done_res)
            flag_mismatch("done_res", got.done_res, want.done_res);
        if (got.nack_seen != want.nack_seen)
            flag_mismatch("nack_seen", got.nack_seen, want.nack_seen);
    endtask

    function automatic i2cm_pkg::t_req_item random_req();
        i2cm_pkg::t_req_item it;
        it.req_type    = i2cm_pkg::t_req_type'($urandom_range(0, 3));
        it.sda_in      = 1'($urandom_range(0, 1));
        it.device_addr = 8'($urandom);
        it.reg_addr    = 8'($urandom);
        it.byte_count  = 5'($urandom);
        it.load_index  = 4'($urandom);
        it.load_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic int xfer_ticks(i2cm_pkg::t_req_type kind, logic [4:0] cnt);
        int n;
        n = (cnt > MAX_WR_BYTES) ? MAX_WR_BYTES : int'(cnt);
        if (kind == i2cm_pkg::REQ_READ)
            return 2 * i2cm_pkg::START_SLOTS + 3 * i2cm_pkg::TX_SLOTS + i2cm_pkg::SHORT_SLOTS
                   + ((n == 0) ? 1 : n) * (i2cm_pkg::RX_SLOTS + i2cm_pkg::SHORT_SLOTS);
        return i2cm_pkg::START_SLOTS + 2 * i2cm_pkg::TX_SLOTS + i2cm_pkg::SHORT_SLOTS
               + n * i2cm_pkg::TX_SLOTS;
    endfunction

    function automatic bit quiet_stretch();
        return req_backlog.size() < TAIL_ITEMS || (req_backlog.size() / 128) % 3 == 1;
    endfunction

    task automatic push_req(i2cm_pkg::t_req_item it, bit hold);
        t_bus_req e;
        e.item = it;
        e.hold = hold;
        req_backlog.push_back(e);
        queued++;
    endtask

    task automatic push_begin(i2cm_pkg::t_req_type kind, logic [7:0] dev, logic [7:0] sub,
                              logic [4:0] cnt, bit hold);
        i2cm_pkg::t_req_item it;
        it             = random_req();
        it.req_type    = kind;
        it.device_addr = dev;
        it.reg_addr    = sub;
        it.byte_count  = cnt;
        push_req(it, hold);
    endtask

    task automatic push_ticks(int n, t_sda_pattern pat, bit busy_noise);
        i2cm_pkg::t_req_item it;
        for (int i = 0; i < n; i++) begin
            it          = random_req();
            it.req_type = i2cm_pkg::REQ_TICK;
            case (pat)
                SDA_LOW:   it.sda_in = 1'b0;
                SDA_HIGH:  it.sda_in = 1'b1;
                SDA_FLAKY: it.sda_in = ($urandom_range(0, 39) == 0);
                default:   it.sda_in = 1'($urandom_range(0, 1));
            endcase
            push_req(it, 1'b0);
            if (busy_noise && $urandom_range(0, 49) == 0) begin
                it          = random_req();
                it.req_type = i2cm_pkg::t_req_type'($urandom_range(1, 3));
                push_req(it, 1'b0);
            end
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!req_if.valid || req_taken)) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                req_if.valid <= 1'b0;
            end else if (req_backlog.size() == 0
                         || (req_backlog[0].hold && rsp_due.size() != 0)) begin
                req_if.valid <= 1'b0;
            end else if (!quiet_stretch() && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 8);
                req_if.valid <= 1'b0;
            end else begin
                req_if.payload <= req_backlog[0].item;
                req_if.valid <= 1'b1;
                void'(req_backlog.pop_front());
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rcv_gap != 0) begin
                rcv_gap <= rcv_gap - 1;
                rsp_if.ready <= 1'b0;
            end else if (!quiet_stretch() && $urandom_range(0, 7) == 0) begin
                rcv_gap <= $urandom_range(0, 8);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        i2cm_pkg::t_rsp_item want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[i2c_master_register_access] ERROR");
            $finish;
        end else begin
            req_taken <= i_rst_n && req_if.valid && req_if.ready;
            if (i_rst_n) begin
                if (rsp_if.valid && rsp_if.ready) begin
                    if (rsp_due.size() == 0) begin
                        flag_mismatch("unexpected response", 1, 0);
                    end else begin
                        want = rsp_due.pop_front();
                        compare_rsp(rsp_if.payload, want);
                    end
                    rsp_seen++;
                end
                if (req_if.valid && req_if.ready) begin
                    bus_step(req_if.payload, want);
                    rsp_due.push_back(want);
                end
            end
        end
    end

    initial begin
        i2cm_pkg::t_req_item it;
        i2cm_pkg::t_req_type kind;
        t_sda_pattern        pat;
        logic [4:0]          cnt;
        int                  n;
        int                  pick;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        req_taken      = 1'b0;
        send_gap       = 0;
        rcv_gap        = 0;
        foreach (wr_buf[i]) wr_buf[i] = '0;

        // fill the whole write buffer before any write goes out
        for (int i = 0; i < MAX_WR_BYTES; i++) begin
            it            = random_req();
            it.req_type   = i2cm_pkg::REQ_LOAD;
            it.load_index = 4'(i);
            it.load_byte  = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom);
            push_req(it, 1'b0);
        end
        push_ticks(1, SDA_HIGH, 1'b0);

        push_begin(i2cm_pkg::REQ_WRITE, 8'h00, 8'hFF, 5'd0, 1'b0);
        push_ticks(xfer_ticks(i2cm_pkg::REQ_WRITE, 5'd0), SDA_LOW, 1'b0);

        // oversized count, with requests that arrive while busy
        push_begin(i2cm_pkg::REQ_WRITE, 8'hFE, 8'h00, 5'd31, 1'b0);
        push_ticks(10, SDA_LOW, 1'b0);
        push_begin(i2cm_pkg::REQ_READ, 8'h10, 8'h20, 5'd2, 1'b0);
        push_begin(i2cm_pkg::REQ_WRITE, 8'h30, 8'h40, 5'd1, 1'b0);
        it            = random_req();
        it.req_type   = i2cm_pkg::REQ_LOAD;
        it.load_index = 4'd0;
        it.load_byte  = 8'h77;
        push_req(it, 1'b0);
        push_ticks(xfer_ticks(i2cm_pkg::REQ_WRITE, 5'd31) - 10, SDA_LOW, 1'b0);

        push_begin(i2cm_pkg::REQ_READ, 8'h20, 8'hA5, 5'd2, 1'b0);
        push_ticks(xfer_ticks(i2cm_pkg::REQ_READ, 5'd2), SDA_RANDOM, 1'b0);

        // missing acknowledge on the device address, after a full drain
        push_begin(i2cm_pkg::REQ_WRITE, 8'h42, 8'h81, 5'd3, 1'b1);
        push_ticks(30, SDA_HIGH, 1'b0);
        // missing acknowledge on the register address
        push_begin(i2cm_pkg::REQ_WRITE, 8'h84, 8'h18, 5'd2, 1'b0);
        push_ticks(24, SDA_LOW, 1'b0);
        push_ticks(26, SDA_HIGH, 1'b0);

        while (queued < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 5)) push_req(random_req(), 1'b0);
            end else if (pick == 1) begin
                repeat ($urandom_range(1, 4)) begin
                    it          = random_req();
                    it.req_type = i2cm_pkg::REQ_LOAD;
                    push_req(it, 1'b0);
                end
            end else begin
                kind = $urandom_range(0, 1) ? i2cm_pkg::REQ_READ : i2cm_pkg::REQ_WRITE;
                cnt  = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 3));
                push_begin(kind, 8'($urandom), 8'($urandom), cnt, $urandom_range(0, 39) == 0);
                n = xfer_ticks(kind, cnt);
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
                if (kind == i2cm_pkg::REQ_READ) pat = SDA_RANDOM;
                else pat = ($urandom_range(0, 3) == 0) ? SDA_FLAKY : SDA_LOW;
                n = n + $urandom_range(0, 2);
                if (queued + n > TOTAL_ITEMS) n = TOTAL_ITEMS - queued;
                push_ticks(n, pat, 1'b1);
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || rsp_due.size() != 0 || req_if.valid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        if (mismatches == 0)
            $display("[i2c_master_register_access] OK");
        else
            $display("[i2c_master_register_access] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/i2cm_pkg.sv
rtl/i2cm_stream_if.sv
rtl/i2c_master_register_access.sv
sim/tb.sv
